### rtl/qrs_pkg.sv
// Shared types and widths for the quadratic root solver.
`default_nettype none
package qrs_pkg;

  localparam int CoefW = 16;
  localparam int RootW = 32;
  localparam int ImagW = 31;
  localparam int DiscW = 34;
  localparam int SqrtW = DiscW / 2;
  localparam int FracW = 16;
  localparam int DenW  = CoefW + 1;
  localparam int NumW  = SqrtW;
  localparam int QuoW  = NumW + FracW;
  localparam int RemW  = DenW - 1;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic signed [RootW-1:0] root_one;
    logic signed [RootW-1:0] root_two;
    logic [ImagW-1:0]        imag_part;
    logic                    is_complex;
    logic                    is_linear;
    logic                    saturated;
  } result_t;

endpackage
`default_nettype wire

### rtl/qrs_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module qrs_div (
  input  wire logic                      clk,
  input  wire logic [qrs_pkg::QuoW-1:0]  num,
  input  wire logic [qrs_pkg::DenW-1:0]  den,
  output logic      [qrs_pkg::QuoW-1:0]  quo
);
  import qrs_pkg::*;

  logic [QuoW-1:0] num_q [0:QuoW];
  logic [DenW-1:0] den_q [0:QuoW];
  logic [RemW-1:0] rem_q [0:QuoW];
  logic [QuoW-1:0] quo_q [0:QuoW];

  always_comb begin
    num_q[0] = num;
    den_q[0] = den;
    rem_q[0] = '0;
    quo_q[0] = '0;
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [DenW-1:0] cur;
    logic            take;
    always_comb begin
      cur  = {rem_q[k], num_q[k][QuoW-1-k]};
      take = (cur >= den_q[k]);
    end
    always_ff @(posedge clk) begin
      num_q[k+1] <= num_q[k];
      den_q[k+1] <= den_q[k];
      rem_q[k+1] <= take ? RemW'(cur - den_q[k]) : cur[RemW-1:0];
      quo_q[k+1] <= {quo_q[k][QuoW-2:0], take};
    end
  end

  assign quo = quo_q[QuoW];

endmodule
`default_nettype wire

### rtl/quadratic_root_solver_top.sv
// Top level of the pipelined quadratic root solver.
`default_nettype none
// The solver takes one coefficient word (a, b, c in signed Q8.8) in every clock cycle:
// busy is always low, so a word is taken at every edge where start is high. Each word
// yields exactly one result word. It appears on result with done high when the output
// register loads it, and it is taken at the next edge. The pipeline has 55 register
// stages, the first of which loads at the accepting edge: one input register, one
// multiply stage, one discriminant stage, 17 square root stages (one root bit each),
// one numerator stage, 33 divider stages (one quotient bit each) and the output
// register.
// The receiver cannot stall the block, so every result must be taken when done is high.
module quadratic_root_solver_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire qrs_pkg::coef_t   coef,
  output logic                  done,
  output qrs_pkg::result_t      result
);
  import qrs_pkg::*;

  localparam int SqSteps = SqrtW;

  // Side data carried alongside the square root stages.
  typedef struct packed {
    logic                    valid;
    logic                    lin;
    logic                    neg;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
  } front_t;

  // Side data carried alongside the divider stages.
  typedef struct packed {
    logic valid;
    logic lin;
    logic neg;
    logic sgn_one;
    logic sgn_two;
  } back_t;

  // The pipeline never stalls, so the block is never busy.
  assign busy = 1'b0;

  // Input register.
  logic  in_valid;
  coef_t in_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    in_coef <= coef;
  end

  // Multiply stage: b*b and a*c, both exact in 32 bits.
  logic                    mul_valid;
  logic signed [31:0]      mul_bb;
  logic signed [31:0]      mul_ac;
  logic signed [CoefW-1:0] mul_a;
  logic signed [CoefW-1:0] mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= in_valid;
    end
    mul_bb <= in_coef.coef_b * in_coef.coef_b;
    mul_ac <= in_coef.coef_a * in_coef.coef_c;
    mul_a  <= in_coef.coef_a;
    mul_b  <= in_coef.coef_b;
  end

  // Discriminant stage: the sign and magnitude of b*b - 4ac.
  logic signed [DiscW:0] disc;
  logic [DiscW-1:0]      disc_mag;

  always_comb begin
    disc     = (DiscW+1)'(mul_bb) - ((DiscW+1)'(mul_ac) <<< 2);
    disc_mag = disc[DiscW] ? DiscW'(-disc) : disc[DiscW-1:0];
  end

  // Square root pipeline, index 0 is the discriminant register.
  logic [SqrtW+1:0] sq_rem  [0:SqSteps];
  logic [SqrtW-1:0] sq_root [0:SqSteps];
  logic [DiscW-1:0] sq_mag  [0:SqSteps];
  front_t           sq_meta [0:SqSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_meta[0] <= '0;
    end else begin
      sq_meta[0].valid <= mul_valid;
      sq_meta[0].lin   <= (mul_a == '0);
      sq_meta[0].neg   <= disc[DiscW];
      sq_meta[0].a     <= mul_a;
      sq_meta[0].b     <= mul_b;
    end
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_mag[0]  <= disc_mag;
  end

  for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
    logic [SqrtW+3:0] cur;
    logic [SqrtW+3:0] trial;
    logic             take;
    always_comb begin
      cur   = {sq_rem[j], sq_mag[j][DiscW-1-2*j -: 2]};
      trial = (SqrtW+4)'({sq_root[j], 2'b01});
      take  = (cur >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_meta[j+1] <= '0;
      end else begin
        sq_meta[j+1] <= sq_meta[j];
      end
      sq_mag[j+1]  <= sq_mag[j];
      sq_rem[j+1]  <= take ? (SqrtW+2)'(cur - trial) : cur[SqrtW+1:0];
      sq_root[j+1] <= {sq_root[j][SqrtW-2:0], take};
    end
  end

  // Numerator stage. A real pair divides -b-r and -b+r by 2a; a complex pair divides
  // -b and r by 2a. The divider works on magnitudes and the signs travel beside it.
  front_t                  fr;
  logic signed [SqrtW+1:0] neg_b;
  logic signed [SqrtW+1:0] root_s;
  logic signed [SqrtW+1:0] num_one;
  logic signed [SqrtW+1:0] num_two;
  logic [NumW-1:0]         mag_one;
  logic [NumW-1:0]         mag_two;
  logic [CoefW-1:0]        a_mag;

  always_comb begin
    fr      = sq_meta[SqSteps];
    neg_b   = -((SqrtW+2)'(fr.b));
    root_s  = (SqrtW+2)'({1'b0, sq_root[SqSteps]});
    if (fr.neg) begin
      num_one = neg_b;
      num_two = root_s;
    end else begin
      num_one = neg_b - root_s;
      num_two = neg_b + root_s;
    end
    mag_one = num_one[SqrtW+1] ? NumW'(-num_one) : num_one[NumW-1:0];
    mag_two = num_two[SqrtW+1] ? NumW'(-num_two) : num_two[NumW-1:0];
    a_mag   = fr.a[CoefW-1] ? CoefW'(-fr.a) : fr.a;
  end

  logic [QuoW-1:0] div_num_one;
  logic [QuoW-1:0] div_num_two;
  logic [DenW-1:0] div_den;
  back_t           bk_meta [0:QuoW];

  always_ff @(posedge clk) begin
    if (rst) begin
      bk_meta[0] <= '0;
    end else begin
      bk_meta[0].valid   <= fr.valid;
      bk_meta[0].lin     <= fr.lin;
      bk_meta[0].neg     <= fr.neg;
      bk_meta[0].sgn_one <= num_one[SqrtW+1] ^ fr.a[CoefW-1];
      bk_meta[0].sgn_two <= num_two[SqrtW+1] ^ fr.a[CoefW-1];
    end
    div_num_one <= {mag_one, FracW'(0)};
    div_num_two <= {mag_two, FracW'(0)};
    div_den     <= {a_mag, 1'b0};
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        bk_meta[k+1] <= '0;
      end else begin
        bk_meta[k+1] <= bk_meta[k];
      end
    end
  end

  logic [QuoW-1:0] quo_one;
  logic [QuoW-1:0] quo_two;

  qrs_div u_div_one (
    .clk (clk),
    .num (div_num_one),
    .den (div_den),
    .quo (quo_one)
  );

  qrs_div u_div_two (
    .clk (clk),
    .num (div_num_two),
    .den (div_den),
    .quo (quo_two)
  );

  // Output stage: apply signs, clip to the 32-bit range, and register the word.
  localparam logic [QuoW-1:0] PosMax = QuoW'(32'h7FFF_FFFF);
  localparam logic [QuoW-1:0] NegMax = QuoW'(33'h0_8000_0000);

  back_t            bk;
  logic [RootW-1:0] val_one;
  logic [RootW-1:0] val_two;
  logic             clip_one;
  logic             clip_two;
  logic             clip_im;
  result_t          res_next;

  always_comb begin
    bk = bk_meta[QuoW];
    if (bk.sgn_one) begin
      clip_one = (quo_one > NegMax);
      val_one  = clip_one ? 32'h8000_0000 : RootW'(QuoW'(0) - quo_one);
    end else begin
      clip_one = (quo_one > PosMax);
      val_one  = clip_one ? 32'h7FFF_FFFF : quo_one[RootW-1:0];
    end
    if (bk.sgn_two) begin
      clip_two = (quo_two > NegMax);
      val_two  = clip_two ? 32'h8000_0000 : RootW'(QuoW'(0) - quo_two);
    end else begin
      clip_two = (quo_two > PosMax);
      val_two  = clip_two ? 32'h7FFF_FFFF : quo_two[RootW-1:0];
    end
    clip_im = (quo_two > PosMax);

    res_next = '0;
    if (bk.lin) begin
      res_next.is_linear = 1'b1;
    end else if (bk.neg) begin
      res_next.root_one   = val_one;
      res_next.root_two   = val_one;
      res_next.imag_part  = clip_im ? {ImagW{1'b1}} : quo_two[ImagW-1:0];
      res_next.is_complex = 1'b1;
      res_next.saturated  = clip_one | clip_im;
    end else begin
      res_next.root_one  = val_one;
      res_next.root_two  = val_two;
      res_next.saturated = clip_one | clip_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bk.valid;
    end
    result <= res_next;
  end

endmodule
`default_nettype wire

### verif/tb_quadratic_root_solver_top.sv
// Testbench for the quadratic root solver: directed and random coefficient words, self-checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_quadratic_root_solver_top;
  import qrs_pkg::*;

  // The drain wait covers the time the block takes to answer a word after it is taken.
  localparam int LatencyCycles = 55;
  localparam int DrainCycles   = LatencyCycles + 20;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  coef_t   coef;
  logic    done;
  result_t result;

  quadratic_root_solver_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .coef   (coef),
    .done   (done),
    .result (result)
  );

  // Coefficient words waiting to be sent, and the roots expected back, oldest first.
  coef_t   pending_coefs[$];
  result_t expected_roots[$];
  int      idle_pct;
  bit      hold_sender;
  bit      stim_done;
  int      fail_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root of a nonnegative value, one result bit at a time.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Q8.8 numerator over 2a, scaled to Q16.16; SystemVerilog division truncates toward zero.
  function automatic longint q16_quotient(longint num, longint den);
    return (num * 65536) / den;
  endfunction

  function automatic logic [31:0] clip_s32(longint v, inout logic clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      v = 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      v = -64'sd2147483648;
    end
    return v[31:0];
  endfunction

  // Works out the roots of one coefficient word.
  function automatic result_t solve_roots(coef_t w);
    result_t res;
    longint  a, b, c, disc, den, rt, re, im;
    longint unsigned mag;
    logic    clipped;
    res     = '0;
    clipped = 1'b0;
    a = longint'(w.coef_a);
    b = longint'(w.coef_b);
    c = longint'(w.coef_c);
    if (a == 0) begin
      res.is_linear = 1'b1;
      return res;
    end
    disc = b * b - 4 * a * c;
    mag  = (disc < 0) ? longint'(-disc) : disc;
    rt   = longint'(floor_sqrt(mag));
    den  = 2 * a;
    if (disc < 0) begin
      re = q16_quotient(-b, den);
      im = q16_quotient(rt, den);
      if (im < 0) im = -im;
      if (im > 64'sd2147483647) begin
        clipped = 1'b1;
        im = 64'sd2147483647;
      end
      res.root_one   = clip_s32(re, clipped);
      res.root_two   = res.root_one;
      res.imag_part  = im[30:0];
      res.is_complex = 1'b1;
    end else begin
      res.root_one = clip_s32(q16_quotient(-b - rt, den), clipped);
      res.root_two = clip_s32(q16_quotient(-b + rt, den), clipped);
    end
    res.saturated = clipped;
    return res;
  endfunction

  function automatic coef_t make_word(int a, int b, int c);
    coef_t w;
    w.coef_a = a[15:0];
    w.coef_b = b[15:0];
    w.coef_c = c[15:0];
    return w;
  endfunction

  // Random word: mostly full-range fields, with some small ones so real, complex and
  // near-zero-discriminant cases all turn up often.
  function automatic coef_t random_word();
    coef_t w;
    w = coef_t'(48'({$urandom, $urandom}));
    case ($urandom_range(0, 5))
      0: w.coef_a = 16'($signed($urandom_range(0, 8)) - 4);
      1: begin
        w.coef_a = 16'($signed($urandom_range(0, 512)) - 256);
        w.coef_c = 16'($signed($urandom_range(0, 512)) - 256);
      end
      2: w.coef_a = '0;
      default: ;
    endcase
    return w;
  endfunction

  // Driver: each word is offered with start high and leaves the queue once taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_roots.push_back(solve_roots(coef));
        void'(pending_coefs.pop_front());
      end
      if (pending_coefs.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        coef  <= pending_coefs[0];
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every word marked by done is checked against the oldest expected roots.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_roots.size() == 0) begin
        $error("result word with no coefficient word outstanding");
        fail_count++;
      end else begin
        want = expected_roots.pop_front();
        if (result.root_one !== want.root_one) begin
          $error("root_one expected %0d actual %0d", want.root_one, result.root_one);
          fail_count++;
        end
        if (result.root_two !== want.root_two) begin
          $error("root_two expected %0d actual %0d", want.root_two, result.root_two);
          fail_count++;
        end
        if (result.imag_part !== want.imag_part) begin
          $error("imag_part expected %0d actual %0d", want.imag_part, result.imag_part);
          fail_count++;
        end
        if (result.is_complex !== want.is_complex) begin
          $error("is_complex expected %0b actual %0b", want.is_complex, result.is_complex);
          fail_count++;
        end
        if (result.is_linear !== want.is_linear) begin
          $error("is_linear expected %0b actual %0b", want.is_linear, result.is_linear);
          fail_count++;
        end
        if (result.saturated !== want.saturated) begin
          $error("saturated expected %0b actual %0b", want.saturated, result.saturated);
          fail_count++;
        end
      end
    end
  end

  // Stimulus in three stretches of differing idle rates, with one full drain in between.
  initial begin
    int phase;
    int k;
    rst         = 1'b1;
    start       = 1'b0;
    coef        = '0;
    idle_pct    = 14;
    hold_sender = 1'b0;
    stim_done   = 1'b0;
    fail_count  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words: field extremes, linear case, zero and negative discriminant,
    // and the words that clip the roots.
    pending_coefs.push_back(make_word(0, 100, 7));
    pending_coefs.push_back(make_word(0, -32768, 32767));
    pending_coefs.push_back(make_word(256, -512, 256));
    pending_coefs.push_back(make_word(256, 0, -256));
    pending_coefs.push_back(make_word(256, 0, 256));
    pending_coefs.push_back(make_word(1, -32768, 0));
    pending_coefs.push_back(make_word(1, 32767, 0));
    pending_coefs.push_back(make_word(-1, -32768, 32767));
    pending_coefs.push_back(make_word(1, 0, 32767));
    pending_coefs.push_back(make_word(-1, 0, -32768));
    pending_coefs.push_back(make_word(32767, 32767, 32767));
    pending_coefs.push_back(make_word(-32768, -32768, -32768));
    pending_coefs.push_back(make_word(-32768, 32767, 32767));
    pending_coefs.push_back(make_word(32767, -32768, -32768));
    pending_coefs.push_back(make_word(-32768, 0, 0));
    pending_coefs.push_back(make_word(1, 1, 1));
    pending_coefs.push_back(make_word(-1, 1, -1));
    pending_coefs.push_back(make_word(-256, 512, -256));
    pending_coefs.push_back(make_word(-32768, -1, 1));

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 62 : 0;
      for (k = 0; k < 630; k++) pending_coefs.push_back(random_word());
      wait (pending_coefs.size() == 0);
      if (phase == 0) begin
        // Hold the sender off until every outstanding result has come back.
        hold_sender = 1'b1;
        wait (expected_roots.size() == 0);
        repeat (5) @(posedge clk);
        hold_sender = 1'b0;
      end
    end
    wait (expected_roots.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
